/* sv/pfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

	// default number of page slots in the bitmap and count memories
	localparam int MAX_PAGES_DEF = 65536;

	// field widths fixed by the interface
	localparam int CMD_W     = 3;
	localparam int IDX_W     = 16;
	localparam int CNT_W     = 17;
	localparam int REF_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [REF_W-1:0] REF_LIMIT      = 16'hFFFF;
	localparam logic [CNT_W-1:0] MANAGED_RESET  = 17'd65536;
	localparam logic [CNT_W-1:0] RESERVE_RESET  = 17'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC_ONE = 3'd0,
		CMD_ALLOC_RUN = 3'd1,
		CMD_FREE_RUN  = 3'd2,
		CMD_ADD_REF   = 3'd3,
		CMD_READ_REF  = 3'd4,
		CMD_RELEASE   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_BAD_ARG   = 3'd2,
		ST_INVALID   = 3'd3,
		ST_DOUBLE    = 3'd4,
		ST_REFUSED   = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MANAGED = 2'd0,
		REG_RESERVE = 2'd1
	} reg_idx_t;

endpackage
`default_nettype wire

/* sv/pfa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* sv/page_frame_allocator.sv */
// Sequencing: each page examined takes a read state (S_RD) and an evaluate state (S_EVAL);
//   run allocation adds S_CHECK per candidate start and S_FILL per page filled. In-range ref
//   commands go from accept through S_RD and S_EVAL to S_OUT. One request at a time;
//   the next accept comes in the cycle after the response handshake.
// Reset: a clearing pass over all MAX_PAGES slots marks every page reserved with a zero count;
//   no request is taken until it ends. Config writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_allocator
	import pfa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CMD_W-1:0]     command,
	input  wire logic [IDX_W-1:0]     page_index,
	input  wire logic [CNT_W-1:0]     page_count,
	input  wire logic [CNT_W-1:0]     align_pages,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2:0]                status,
	output logic [IDX_W-1:0]          result_page,
	output logic [CNT_W-1:0]          result_value,
	output logic [CNT_W-1:0]          free_count
);

	localparam int PW = $clog2(MAX_PAGES);
	localparam int CW = ((PW > CNT_W) ? PW : CNT_W) + 2;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_RD    = 7'b0001000,
		S_EVAL  = 7'b0010000,
		S_FILL  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [CMD_W-1:0]  cmd_q, cmd_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     mask_q, mask_d;
	logic [CW-1:0]     p_q, p_d;
	logic [CW-1:0]     e_q, e_d;
	logic [CW-1:0]     first_q, first_d;
	logic              pass_q, pass_d;
	logic [CW-1:0]     hint_q, hint_d;
	logic [CW-1:0]     free_q, free_d;
	logic [CNT_W-1:0]  rval_q, rval_d;
	logic [IDX_W-1:0]  rpage_q, rpage_d;
	logic [2:0]        status_q, status_d;
	logic [CNT_W-1:0]  managed_q;
	logic [PW-1:0]     clr_q, clr_d;

	logic [CW-1:0]     total;
	logic [CW-1:0]     max_pages_w;
	logic [CW-1:0]     p_inc;
	logic [CW-1:0]     idx_w;
	logic [CW-1:0]     idx_end;
	logic [CW-1:0]     stride;
	logic [CW-1:0]     aln_w;
	logic              cfg_wr;

	logic [PW-1:0]     mem_addr;
	logic              map_we, map_wd, map_rd;
	logic              ref_we;
	logic [REF_W-1:0]  ref_wd, ref_rd;

	pfa_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (mem_addr),
		.wdata (map_wd),
		.raddr (mem_addr),
		.rdata (map_rd)
	);

	pfa_ram #(.WIDTH(REF_W), .DEPTH(MAX_PAGES)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (mem_addr),
		.wdata (ref_wd),
		.raddr (mem_addr),
		.rdata (ref_rd)
	);

	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid & cfg_ready;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = (state_q == S_OUT);
	assign status       = status_q;
	assign result_page  = rpage_q;
	assign result_value = rval_q;
	assign free_count   = free_q[CNT_W-1:0];

	// effective page total and shared arithmetic
	assign max_pages_w = CW'(MAX_PAGES);
	assign total       = (CW'(managed_q) > max_pages_w) ? max_pages_w : CW'(managed_q);
	assign p_inc       = p_q + CW'(1);
	assign idx_w       = CW'(page_index);
	assign idx_end     = idx_w + CW'(page_count);
	assign aln_w       = CW'(align_pages);
	assign stride      = (aln_w > CW'(1)) ? aln_w : CW'(1);

	// sequencer
	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		cnt_d    = cnt_q;
		mask_d   = mask_q;
		p_d      = p_q;
		e_d      = e_q;
		first_d  = first_q;
		pass_d   = pass_q;
		hint_d   = hint_q;
		free_d   = free_q;
		rval_d   = rval_q;
		rpage_d  = rpage_q;
		status_d = status_q;
		clr_d    = clr_q;
		mem_addr = p_q[PW-1:0];
		map_we   = 1'b0;
		map_wd   = 1'b0;
		ref_we   = 1'b0;
		ref_wd   = '0;

		case (state_q)
			S_CLEAR: begin
				mem_addr = clr_q;
				map_we   = 1'b1;
				map_wd   = 1'b1;
				ref_we   = 1'b1;
				clr_d    = clr_q + PW'(1);
				if (clr_q == PW'(MAX_PAGES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd_d    = command;
					cnt_d    = CW'(page_count);
					status_d = ST_OK;
					rval_d   = '0;
					rpage_d  = '0;
					pass_d   = 1'b0;
					p_d      = idx_w;
					e_d      = idx_w + CW'(1);
					state_d  = S_RD;
					case (command)
						CMD_ALLOC_ONE: begin
							p_d = hint_q;
							e_d = total;
							if (free_q == '0) begin
								status_d = ST_NO_SPACE;
								state_d  = S_OUT;
							end
						end
						CMD_ALLOC_RUN: begin
							first_d = stride;
							mask_d  = stride - CW'(1);
							state_d = S_CHECK;
							if (page_count == '0 || (align_pages & (align_pages - CNT_W'(1))) != '0)
							begin
								status_d = ST_BAD_ARG;
								state_d  = S_OUT;
							end else if (free_q < CW'(page_count)) begin
								status_d = ST_NO_SPACE;
								state_d  = S_OUT;
							end
						end
						CMD_FREE_RUN: begin
							e_d = idx_end;
							if (page_index == '0 || page_count == '0) begin
								state_d = S_OUT;
							end
						end
						CMD_ADD_REF: begin
							if (idx_w >= total) begin
								status_d = ST_REFUSED;
								state_d  = S_OUT;
							end
						end
						CMD_READ_REF: begin
							if (idx_w >= total) begin
								state_d = S_OUT;
							end
						end
						CMD_RELEASE: begin
							e_d = (idx_end > total) ? total : idx_end;
						end
						default: begin
							status_d = ST_BAD_ARG;
							state_d  = S_OUT;
						end
					endcase
				end
			end
			// candidate run start: does it still fit
			S_CHECK: begin
				if (first_q + cnt_q > total) begin
					status_d = ST_NO_SPACE;
					state_d  = S_OUT;
				end else begin
					p_d     = first_q;
					e_d     = first_q + cnt_q;
					state_d = S_RD;
				end
			end
			// range end, out-of-range free page, or issue a read of page p
			S_RD: begin
				if (p_q >= e_q) begin
					case (cmd_q)
						CMD_ALLOC_ONE: begin
							if (!pass_q) begin
								pass_d = 1'b1;
								p_d    = '0;
								e_d    = (hint_q > total) ? total : hint_q;
							end else begin
								status_d = ST_NO_SPACE;
								state_d  = S_OUT;
							end
						end
						CMD_ALLOC_RUN: begin
							p_d     = first_q;
							state_d = S_FILL;
						end
						default: state_d = S_OUT;
					endcase
				end else if (cmd_q == CMD_FREE_RUN && p_q >= total) begin
					status_d = ST_INVALID;
					state_d  = S_OUT;
				end else begin
					state_d = S_EVAL;
				end
			end
			// read data is back: decide and write
			S_EVAL: begin
				p_d     = p_inc;
				state_d = S_RD;
				case (cmd_q)
					CMD_ALLOC_ONE: begin
						if (!map_rd) begin
							map_we  = 1'b1;
							map_wd  = 1'b1;
							ref_we  = 1'b1;
							ref_wd  = REF_W'(1);
							free_d  = free_q - CW'(1);
							hint_d  = (p_inc >= total) ? '0 : p_inc;
							rpage_d = p_q[IDX_W-1:0];
							state_d = S_OUT;
						end
					end
					CMD_ALLOC_RUN: begin
						if (map_rd) begin
							first_d = (p_q & ~mask_q) + mask_q + CW'(1);
							state_d = S_CHECK;
						end
					end
					CMD_FREE_RUN: begin
						if (!map_rd) begin
							status_d = ST_DOUBLE;
							state_d  = S_OUT;
						end else if (ref_rd > REF_W'(1)) begin
							ref_we = 1'b1;
							ref_wd = ref_rd - REF_W'(1);
						end else begin
							ref_we = 1'b1;
							map_we = 1'b1;
							free_d = free_q + CW'(1);
							if (p_q < hint_q) hint_d = p_q;
						end
					end
					CMD_ADD_REF: begin
						state_d = S_OUT;
						if (!map_rd || ref_rd == REF_LIMIT) begin
							status_d = ST_REFUSED;
						end else begin
							ref_we = 1'b1;
							ref_wd = ref_rd + REF_W'(1);
						end
					end
					CMD_READ_REF: begin
						state_d = S_OUT;
						rval_d  = map_rd ? CNT_W'(ref_rd) : '0;
					end
					CMD_RELEASE: begin
						if (map_rd && ref_rd == '0) begin
							ref_we = 1'b1;
							map_we = 1'b1;
							free_d = free_q + CW'(1);
							rval_d = rval_q + CNT_W'(1);
							if (p_q < hint_q) hint_d = p_q;
						end
					end
					default: state_d = S_OUT;
				endcase
			end
			// mark the found run allocated, one page a cycle
			S_FILL: begin
				if (p_q < e_q) begin
					map_we = 1'b1;
					map_wd = 1'b1;
					ref_we = 1'b1;
					ref_wd = REF_W'(1);
					p_d    = p_inc;
				end else begin
					free_d  = free_q - cnt_q;
					rpage_d = first_q[IDX_W-1:0];
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		// reserve write reloads the hint
		if (cfg_wr && cfg_index == REG_RESERVE) begin
			hint_d = CW'(cfg_data);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			free_q    <= '0;
			hint_q    <= CW'(RESERVE_RESET);
			managed_q <= MANAGED_RESET;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			free_q  <= free_d;
			hint_q  <= hint_d;
			if (cfg_wr && cfg_index == REG_MANAGED) begin
				managed_q <= cfg_data;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		cnt_q    <= cnt_d;
		mask_q   <= mask_d;
		p_q      <= p_d;
		e_q      <= e_d;
		first_q  <= first_d;
		pass_q   <= pass_d;
		rval_q   <= rval_d;
		rpage_q  <= rpage_d;
		status_q <= status_d;
	end

endmodule
`default_nettype wire

/* tb/page_frame_allocator_test.sv */
`timescale 1ns / 1ps
module page_frame_allocator_test;
	import pfa_pkg::*;

	localparam int NPAGES = 65536;
	localparam int STALL_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
	localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = '0;
	logic [IDX_W-1:0] page_index = '0;
	logic [CNT_W-1:0] page_count = '0;
	logic [CNT_W-1:0] align_pages = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [IDX_W-1:0] result_page;
	logic [CNT_W-1:0] result_value;
	logic [CNT_W-1:0] free_count;

	page_frame_allocator dut (.*);

	// result of one request
	typedef struct packed {
		logic [2:0] st;
		logic [IDX_W-1:0] pg;
		logic [CNT_W-1:0] val;
		logic [CNT_W-1:0] fc;
	} alloc_result_t;

	typedef struct {
		logic [2:0] cmd;
		int idx;
		int cnt;
		int aln;
		bit typed;
		alloc_result_t res;
	} row_t;

	// shadow allocator state
	bit mirror_map [NPAGES];
	logic [REF_W-1:0] mirror_ref [NPAGES];
	longint mirror_free;
	longint mirror_hint;
	longint mirror_managed;

	alloc_result_t pending_q [$];
	int mismatches = 0;
	int n_requests = 0;
	int n_results = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit page_taken(longint p);
		if (p >= NPAGES) return 1'b1;
		return mirror_map[p];
	endfunction

	function automatic void release_page(longint p);
		mirror_ref[p] = '0;
		mirror_map[p] = 1'b0;
		mirror_free++;
		if (p < mirror_hint) mirror_hint = p;
	endfunction

	// next-fit / run allocator model: updates shadow state, returns the response
	function automatic alloc_result_t allocator_step(logic [2:0] cmd, longint idx,
			longint cnt, longint aln);
		alloc_result_t r;
		longint total, b, e, p, first, stride, last;
		bit found;
		r = '0;
		total = (mirror_managed > NPAGES) ? NPAGES : mirror_managed;
		found = 1'b0;
		case (cmd)
			CMD_ALLOC_ONE: begin
				if (mirror_free != 0) begin
					for (int pass = 0; pass < 2 && !found; pass++) begin
						b = (pass == 0) ? mirror_hint : 0;
						e = (pass == 0) ? total : mirror_hint;
						if (e > total) e = total;
						for (p = b; p < e; p++) begin
							if (!page_taken(p)) begin
								mirror_map[p] = 1'b1;
								mirror_ref[p] = 16'd1;
								mirror_free--;
								mirror_hint = p + 1;
								if (mirror_hint >= total) mirror_hint = 0;
								r.pg = p[IDX_W-1:0];
								found = 1'b1;
								break;
							end
						end
					end
				end
				if (!found) r.st = ST_NO_SPACE;
			end
			CMD_ALLOC_RUN: begin
				stride = (aln > 1) ? aln : 1;
				if (cnt == 0 || (aln & (aln - 1)) != 0) begin
					r.st = ST_BAD_ARG;
				end else begin
					if (mirror_free >= cnt) begin
						for (first = stride; first + cnt <= total; first += stride) begin
							p = first;
							while (p < first + cnt && !page_taken(p)) p++;
							if (p < first + cnt) begin
								first = p - (p % stride);
								continue;
							end
							for (p = first; p < first + cnt; p++) begin
								mirror_map[p] = 1'b1;
								mirror_ref[p] = 16'd1;
							end
							mirror_free -= cnt;
							r.pg = first[IDX_W-1:0];
							found = 1'b1;
							break;
						end
					end
					if (!found) r.st = ST_NO_SPACE;
				end
			end
			CMD_FREE_RUN: begin
				if (idx != 0 && cnt != 0) begin
					for (longint i = 0; i < cnt; i++) begin
						p = idx + i;
						if (p >= total) begin
							r.st = ST_INVALID;
							break;
						end
						if (!page_taken(p)) begin
							r.st = ST_DOUBLE;
							break;
						end
						if (mirror_ref[p] > 1) mirror_ref[p]--;
						else release_page(p);
					end
				end
			end
			CMD_ADD_REF: begin
				if (idx >= total || !page_taken(idx) || mirror_ref[idx] == REF_LIMIT)
					r.st = ST_REFUSED;
				else
					mirror_ref[idx]++;
			end
			CMD_READ_REF: begin
				if (idx < total && page_taken(idx)) r.val = {1'b0, mirror_ref[idx]};
			end
			CMD_RELEASE: begin
				if (cnt != 0) begin
					last = idx + cnt;
					if (last > total) last = total;
					for (p = idx; p < last; p++) begin
						if (!page_taken(p) || mirror_ref[p] != 0) continue;
						release_page(p);
						r.val++;
					end
				end
			end
			default: r.st = ST_BAD_ARG;
		endcase
		r.fc = mirror_free[CNT_W-1:0];
		return r;
	endfunction

	// send one request; typed rows carry a hand-written expectation
	task automatic send_request(logic [2:0] cmd, int idx, int cnt, int aln, bit typed,
			alloc_result_t hand);
		int gap;
		alloc_result_t pr;
		gap = 0;
		case ($urandom_range(0, 9))
			0: gap = $urandom_range(10, 40);
			1, 2, 3: gap = $urandom_range(1, 3);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		page_index <= idx[IDX_W-1:0];
		page_count <= cnt[CNT_W-1:0];
		align_pages <= aln[CNT_W-1:0];
		do @(posedge clk); while (!in_ready);
		pr = allocator_step(cmd, idx & 16'hFFFF, cnt & 17'h1FFFF, aln & 17'h1FFFF);
		pending_q.push_back(typed ? hand : pr);
		n_requests++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, int data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == REG_MANAGED) begin
			mirror_managed = data & 17'h1FFFF;
		end else if (index == REG_RESERVE) begin
			mirror_hint = data & 17'h1FFFF;
		end
		@(posedge clk);
	endtask

	// mostly well-formed traffic against a small page pool, some wild fields
	task automatic random_request(int total);
		int r, idx, cnt, aln, wild;
		logic [2:0] cmd;
		r = $urandom_range(0, 99);
		wild = ($urandom_range(0, 9) == 0);
		idx = wild ? $urandom_range(0, 65535) : $urandom_range(0, total + 1);
		cnt = wild ? $urandom_range(0, 131071) : $urandom_range(1, 6);
		aln = 0;
		if (r < 25) begin
			cmd = CMD_ALLOC_ONE;
		end else if (r < 40) begin
			cmd = CMD_ALLOC_RUN;
			aln = wild ? $urandom_range(0, 131071) : (1 << $urandom_range(0, 3)) >> 1;
		end else if (r < 60) begin
			cmd = CMD_FREE_RUN;
		end else if (r < 72) begin
			cmd = CMD_ADD_REF;
		end else if (r < 82) begin
			cmd = CMD_READ_REF;
		end else if (r < 95) begin
			cmd = CMD_RELEASE;
			if (!wild) cnt = $urandom_range(0, 16);
		end else begin
			cmd = $urandom_range(0, 1) ? CMD_UNDEF_6 : CMD_UNDEF_7;
			aln = $urandom_range(0, 131071);
		end
		send_request(cmd, idx, cnt, aln, 1'b0, '0);
	endtask

	// receiver: random back-pressure, plus one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 9) < 7) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
				else repeat ($urandom_range(1, 3)) @(posedge clk);
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		alloc_result_t want;
		if (out_valid && out_ready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: st=%0d pg=%0d val=%0d fc=%0d",
						status, result_page, result_value, free_count);
			end else begin
				want = pending_q.pop_front();
				if (want.st !== status || want.pg !== result_page ||
						want.val !== result_value || want.fc !== free_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response %0d: exp st=%0d pg=%0d val=%0d fc=%0d, %s",
							n_results, want.st, want.pg, want.val, want.fc,
							$sformatf("got st=%0d pg=%0d val=%0d fc=%0d",
								status, result_page, result_value, free_count));
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		row_t dir [22];
		int phase_managed [5];
		int phase_reserve [5];
		int total;

		for (int p = 0; p < NPAGES; p++) begin
			mirror_map[p] = 1'b1;
			mirror_ref[p] = '0;
		end
		mirror_free = 0;
		mirror_hint = RESERVE_RESET;
		mirror_managed = MANAGED_RESET;

		dir = '{
			'{CMD_READ_REF,  0,     0,      0,     1, '{ST_OK, 0, 0, 0}},
			'{CMD_ALLOC_ONE, 0,     0,      0,     1, '{ST_NO_SPACE, 0, 0, 0}},
			'{CMD_UNDEF_7,   65535, 131071, 131071, 1, '{ST_BAD_ARG, 0, 0, 0}},
			'{CMD_UNDEF_6,   0,     0,      0,     1, '{ST_BAD_ARG, 0, 0, 0}},
			'{CMD_ALLOC_RUN, 0,     0,      0,     1, '{ST_BAD_ARG, 0, 0, 0}},
			'{CMD_ALLOC_RUN, 0,     2,      3,     1, '{ST_BAD_ARG, 0, 0, 0}},
			'{CMD_ALLOC_RUN, 0,     65536,  65536, 1, '{ST_NO_SPACE, 0, 0, 0}},
			'{CMD_FREE_RUN,  0,     5,      0,     1, '{ST_OK, 0, 0, 0}},
			'{CMD_FREE_RUN,  100,   0,      0,     1, '{ST_OK, 0, 0, 0}},
			'{CMD_ADD_REF,   10,    0,      0,     1, '{ST_OK, 0, 0, 0}},
			'{CMD_READ_REF,  10,    0,      0,     1, '{ST_OK, 0, 1, 0}},
			'{CMD_RELEASE,   8,     4,      0,     1, '{ST_OK, 0, 3, 3}},
			'{CMD_RELEASE,   300,   4,      0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_ALLOC_ONE, 0,     0,      0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_ALLOC_RUN, 0,     2,      4,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_ADD_REF,   9,     0,      0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_FREE_RUN,  65535, 65536,  0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_READ_REF,  65535, 0,      0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_FREE_RUN,  8,     1,      0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_FREE_RUN,  8,     1,      0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_RELEASE,   0,     131071, 0,     0, '{ST_OK, 0, 0, 0}},
			'{CMD_ALLOC_RUN, 0,     65535,  1,     0, '{ST_OK, 0, 0, 0}}
		};
		phase_managed = '{64, 128, 1, 200, 96};
		phase_reserve = '{0, 65536, 65536, 17, 5};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at the reset configuration
		foreach (dir[i])
			send_request(dir[i].cmd, dir[i].idx, dir[i].cnt, dir[i].aln, dir[i].typed,
				dir[i].res);

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_MANAGED, phase_managed[ph]);
			write_reg(REG_RESERVE, phase_reserve[ph]);
			total = phase_managed[ph];
			for (int n = 0; n < 280; n++) begin
				if (ph == 0 && n == 60) hold_req = 1'b1;
				if (ph == 1 && n == 140) wait_drained();
				random_request(total);
			end
		end

		// back to the widest pool, unused register index, managed above the pool size
		write_reg(REG_UNUSED, 5);
		write_reg(REG_MANAGED, 131071);
		write_reg(REG_RESERVE, 0);
		send_request(CMD_ALLOC_ONE, 0, 0, 0, 1'b0, '0);
		send_request(CMD_READ_REF, 65535, 0, 0, 1'b0, '0);
		send_request(CMD_FREE_RUN, 65534, 4, 0, 1'b0, '0);
		send_request(CMD_ALLOC_RUN, 0, 16, 65536, 1'b0, '0);
		send_request(CMD_ALLOC_RUN, 0, 4, 16, 1'b0, '0);

		wait_drained();
		repeat (50) @(posedge clk);
		$display("Ran %0d requests, %0d responses: reset pool, five small pools, full pool,",
			n_requests, n_results);
		$display("with bad arguments, double frees, wrapped hints and a long output hold.");
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/pfa_pkg.sv
sv/pfa_ram.sv
sv/page_frame_allocator.sv
tb/page_frame_allocator_test.sv
